/* hw/rtl/hbcs_pkg.sv */
package hbcs_pkg;

	// Writable register addresses
	localparam logic [7:0] ADDR_CMD   = 8'h04;
	localparam logic [7:0] ADDR_STS   = 8'h07;
	localparam logic [7:0] ADDR_LAT   = 8'h0D;
	localparam logic [7:0] ADDR_BIST  = 8'h0F;
	localparam logic [7:0] ADDR_PCON  = 8'h50;
	localparam logic [7:0] ADDR_CC    = 8'h52;
	localparam logic [7:0] ADDR_DRAMC = 8'h57;
	localparam logic [7:0] ADDR_PAM0  = 8'h58;
	localparam logic [7:0] ADDR_PAM1  = 8'h59;
	localparam logic [7:0] ADDR_PAM2  = 8'h5A;
	localparam logic [7:0] ADDR_PAM3  = 8'h5B;
	localparam logic [7:0] ADDR_PAM4  = 8'h5C;
	localparam logic [7:0] ADDR_PAM5  = 8'h5D;
	localparam logic [7:0] ADDR_PAM6  = 8'h5E;
	localparam logic [7:0] ADDR_PAM7  = 8'h5F;
	localparam logic [7:0] ADDR_SMRAM = 8'h72;

	// Upper address bits shared by the shadow attribute block 0x58..0x5F
	localparam logic [4:0] PAM_BLOCK = 5'b01011;
	localparam int         PAM_REGIONS = 6;

	// Write masks and forced bits
	localparam logic [7:0] CMD_MASK      = 8'h02;
	localparam logic [7:0] CMD_FIXED     = 8'h04;
	localparam logic [7:0] STS_MASK      = 8'h03;
	localparam logic [7:0] LAT_MASK      = 8'hF8;
	localparam logic [7:0] BIST_MASK     = 8'h40;
	localparam logic [7:0] PCON_MASK     = 8'hEF;
	localparam logic [7:0] CC_WMASK      = 8'hFB;
	localparam logic [7:0] CC_MASK       = 8'h3B;
	localparam logic [7:0] CC_EN         = 8'h40;
	localparam logic [7:0] DRAMC_MASK    = 8'hCF;
	localparam logic [7:0] PAM_MASK      = 8'h77;
	localparam logic [7:0] SMRAM_LK_MASK = 8'h2F;
	localparam logic [7:0] SMRAM_MASK    = 8'h7F;
	localparam logic [7:0] SMRAM_LOCK    = 8'h10;
	localparam logic [7:0] SMRAM_CLR_OPN = 8'h3F;

	// Byte returned for an absent function
	localparam logic [7:0] NO_FUNC_DATA = 8'hFF;

	// Request kinds
	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// Bit positions of decoded registers
	localparam int SMRAM_CLS_BIT = 5;
	localparam int SMRAM_OPN_BIT = 6;
	localparam int SMRAM_EN_BIT  = 3;
	localparam int SMRAM_LK_BIT  = 4;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} st_t;

	// Power-on contents of the configuration space
	function automatic logic [7:0] reset_byte(input logic [7:0] a);
		logic [7:0] v;
		unique case (a)
			8'h00: v = 8'h86;
			8'h01: v = 8'h80;
			8'h02: v = 8'h2D;
			8'h03: v = 8'h12;
			8'h04: v = 8'h06;
			8'h07: v = 8'h02;
			8'h08: v = 8'h02;
			8'h0B: v = 8'h06;
			8'h52: v = 8'h10;
			8'h57: v = 8'h01;
			8'h60: v = 8'h02;
			8'h61: v = 8'h02;
			8'h62: v = 8'h02;
			8'h63: v = 8'h02;
			8'h64: v = 8'h02;
			8'h72: v = 8'h02;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

/* hw/rtl/hbcs_req_if.sv */
interface hbcs_req_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [2:0] func;
	logic [7:0] reg_addr;
	logic [7:0] wdata;

	modport source(output valid, kind, func, reg_addr, wdata, input ready);
	modport sink(input valid, kind, func, reg_addr, wdata, output ready);
endinterface

/* hw/rtl/hbcs_rsp_if.sv */
interface hbcs_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  rdata;
	logic        cache_ext_on;
	logic        dram_hole_on;
	logic [12:0] pam_read_internal;
	logic [12:0] pam_write_internal;
	logic        smram_on;
	logic        smram_open;

	modport source(output valid, rdata, cache_ext_on, dram_hole_on, pam_read_internal,
		pam_write_internal, smram_on, smram_open, input ready);
	modport sink(input valid, rdata, cache_ext_on, dram_hole_on, pam_read_internal,
		pam_write_internal, smram_on, smram_open, output ready);
endinterface

/* hw/rtl/host_bridge_config_space.sv */
// A request accepted in the idle state is captured and its byte is read from
// memory; the result is loaded into the output register once that is free.
// The single-port byte memory is read at acceptance, then the byte is modified and
// written back; no new request is taken until the current one has been executed.
// A waiting result holds the write-back, and with it the input, until taken.
// Reset clears the per-byte valid bits at once; unwritten bytes read as their
// power-on defaults, so no clearing pass is needed.
module host_bridge_config_space (
	input  logic           clk,
	input  logic           arst_n,
	hbcs_req_if.sink       req,
	hbcs_rsp_if.source     rsp
);

	hbcs_pkg::st_t st_q, st_d;

	logic       req_acc;
	logic       exec_go;
	logic       out_free;

	// Request captured at acceptance
	logic       kind_s1;
	logic [2:0] func_s1;
	logic [7:0] addr_s1;
	logic [7:0] wdata_s1;

	// Byte memory and its valid bits
	logic [7:0]   mem_q [256];
	logic [255:0] vld_q;
	logic [7:0]   rd_s1;
	logic         rdv_s1;

	logic [7:0] old_byte;
	logic [7:0] new_byte;
	logic       wr_en;

	// Copies of the registers that feed the decoded map
	logic [7:0] cc_q;
	logic [7:0] dramc_q;
	logic [7:0] smram_q;
	logic [7:0] pam_q [8];

	logic       out_valid_q;
	logic [7:0] rdata_q;

	logic [12:0] pam_rd;
	logic [12:0] pam_wr;

	function automatic logic is_writable(input logic [7:0] a);
		logic w;
		unique case (a)
			hbcs_pkg::ADDR_CMD, hbcs_pkg::ADDR_STS, hbcs_pkg::ADDR_LAT,
			hbcs_pkg::ADDR_BIST, hbcs_pkg::ADDR_PCON, hbcs_pkg::ADDR_CC,
			hbcs_pkg::ADDR_DRAMC, hbcs_pkg::ADDR_PAM0, hbcs_pkg::ADDR_PAM1,
			hbcs_pkg::ADDR_PAM2, hbcs_pkg::ADDR_PAM3, hbcs_pkg::ADDR_PAM4,
			hbcs_pkg::ADDR_PAM5, hbcs_pkg::ADDR_PAM6, hbcs_pkg::ADDR_PAM7,
			hbcs_pkg::ADDR_SMRAM: w = 1'b1;
			default: w = 1'b0;
		endcase
		return w;
	endfunction

	function automatic logic [7:0] apply_write(input logic [7:0] a, input logic [7:0] old,
		input logic [7:0] w);
		logic [7:0] n;
		n = old;
		unique case (a)
			hbcs_pkg::ADDR_CMD:   n = (w & hbcs_pkg::CMD_MASK) | hbcs_pkg::CMD_FIXED;
			hbcs_pkg::ADDR_STS:   n = old & w & hbcs_pkg::STS_MASK;
			hbcs_pkg::ADDR_LAT:   n = w & hbcs_pkg::LAT_MASK;
			hbcs_pkg::ADDR_BIST:  n = w & hbcs_pkg::BIST_MASK;
			hbcs_pkg::ADDR_PCON:  n = w & hbcs_pkg::PCON_MASK;
			hbcs_pkg::ADDR_CC: begin
				n = w & hbcs_pkg::CC_WMASK & hbcs_pkg::CC_MASK;
				if (n[1:0] == 2'b11) begin
					n = n | hbcs_pkg::CC_EN;
				end
			end
			hbcs_pkg::ADDR_DRAMC: n = w & hbcs_pkg::DRAMC_MASK;
			hbcs_pkg::ADDR_PAM0:  n = w;
			hbcs_pkg::ADDR_PAM1, hbcs_pkg::ADDR_PAM2, hbcs_pkg::ADDR_PAM3,
			hbcs_pkg::ADDR_PAM4, hbcs_pkg::ADDR_PAM5, hbcs_pkg::ADDR_PAM6,
			hbcs_pkg::ADDR_PAM7:  n = w & hbcs_pkg::PAM_MASK;
			hbcs_pkg::ADDR_SMRAM: begin
				if (old[hbcs_pkg::SMRAM_LK_BIT]) begin
					n = (w & hbcs_pkg::SMRAM_LK_MASK) | hbcs_pkg::SMRAM_LOCK;
				end else begin
					n = w & hbcs_pkg::SMRAM_MASK;
				end
				// a set lock always hides the open bit
				if (n[hbcs_pkg::SMRAM_LK_BIT]) begin
					n = n & hbcs_pkg::SMRAM_CLR_OPN;
				end
			end
			default: n = old;
		endcase
		return n;
	endfunction

	// Next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			hbcs_pkg::ST_IDLE: begin
				if (req.valid) begin
					st_d = hbcs_pkg::ST_EXEC;
				end
			end
			hbcs_pkg::ST_EXEC: begin
				if (out_free) begin
					st_d = hbcs_pkg::ST_IDLE;
				end
			end
			default: st_d = hbcs_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		req.ready = 1'b0;
		exec_go   = 1'b0;
		unique case (st_q)
			hbcs_pkg::ST_IDLE: req.ready = 1'b1;
			hbcs_pkg::ST_EXEC: exec_go = out_free;
			default: begin
				req.ready = 1'b0;
				exec_go   = 1'b0;
			end
		endcase
	end

	assign out_free = !out_valid_q || rsp.ready;
	assign req_acc  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= hbcs_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (req_acc) begin
			kind_s1  <= req.kind;
			func_s1  <= req.func;
			addr_s1  <= req.reg_addr;
			wdata_s1 <= req.wdata;
		end
	end

	// Memory read port, registered
	always_ff @(posedge clk) begin
		if (req_acc) begin
			rd_s1 <= mem_q[req.reg_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1 <= 1'b0;
		end else if (req_acc) begin
			rdv_s1 <= vld_q[req.reg_addr];
		end
	end

	// Modify: unwritten bytes take their power-on value
	assign old_byte = rdv_s1 ? rd_s1 : hbcs_pkg::reset_byte(addr_s1);
	assign wr_en    = exec_go && (kind_s1 == hbcs_pkg::KIND_WRITE) && (func_s1 == 3'd0)
		&& is_writable(addr_s1);
	assign new_byte = wr_en ? apply_write(addr_s1, old_byte, wdata_s1) : old_byte;

	// Write back
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr_s1] <= new_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[addr_s1] <= 1'b1;
		end
	end

	// Track the decoded registers alongside the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q    <= hbcs_pkg::reset_byte(hbcs_pkg::ADDR_CC);
			dramc_q <= hbcs_pkg::reset_byte(hbcs_pkg::ADDR_DRAMC);
			smram_q <= hbcs_pkg::reset_byte(hbcs_pkg::ADDR_SMRAM);
			for (int i = 0; i < 8; i++) begin
				pam_q[i] <= 8'h00;
			end
		end else if (wr_en) begin
			if (addr_s1 == hbcs_pkg::ADDR_CC) begin
				cc_q <= new_byte;
			end
			if (addr_s1 == hbcs_pkg::ADDR_DRAMC) begin
				dramc_q <= new_byte;
			end
			if (addr_s1 == hbcs_pkg::ADDR_SMRAM) begin
				smram_q <= new_byte;
			end
			if (addr_s1[7:3] == hbcs_pkg::PAM_BLOCK) begin
				pam_q[addr_s1[2:0]] <= new_byte;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			rdata_q <= (func_s1 != 3'd0) ? hbcs_pkg::NO_FUNC_DATA : new_byte;
		end
	end

	// Decode the shadow map: F0000 first, then C0000..EC000 low/high halves
	always_comb begin
		pam_rd    = '0;
		pam_wr    = '0;
		pam_rd[0] = pam_q[1][4];
		pam_wr[0] = pam_q[1][5];
		for (int i = 0; i < hbcs_pkg::PAM_REGIONS; i++) begin
			pam_rd[1 + 2 * i] = pam_q[2 + i][0];
			pam_rd[2 + 2 * i] = pam_q[2 + i][4];
			pam_wr[1 + 2 * i] = pam_q[2 + i][1];
			pam_wr[2 + 2 * i] = pam_q[2 + i][5];
		end
	end

	// Decoded flags hold while a result waits, since no write-back happens then
	assign rsp.valid              = out_valid_q;
	assign rsp.rdata              = rdata_q;
	assign rsp.cache_ext_on       = (cc_q[1:0] == 2'b11);
	assign rsp.dram_hole_on       = (dramc_q[7:6] == 2'b01);
	assign rsp.pam_read_internal  = pam_rd;
	assign rsp.pam_write_internal = pam_wr;
	assign rsp.smram_on           = smram_q[hbcs_pkg::SMRAM_EN_BIT];
	assign rsp.smram_open         = smram_q[hbcs_pkg::SMRAM_EN_BIT]
		&& smram_q[hbcs_pkg::SMRAM_OPN_BIT] && !smram_q[hbcs_pkg::SMRAM_CLS_BIT];

	a_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		smram_q[hbcs_pkg::SMRAM_LK_BIT] |=> smram_q[hbcs_pkg::SMRAM_LK_BIT])
		else $error("SMRAM lock cleared without reset");

	a_lock_hides_open: assert property (@(posedge clk) disable iff (!arst_n)
		smram_q[hbcs_pkg::SMRAM_LK_BIT] |-> !smram_q[hbcs_pkg::SMRAM_OPN_BIT])
		else $error("SMRAM open while locked");

	a_cc_enable: assert property (@(posedge clk) disable iff (!arst_n)
		cc_q[6] == (cc_q[1:0] == 2'b11))
		else $error("cache enable bit out of step with its controls");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (st_q == hbcs_pkg::ST_EXEC))
		else $error("accepted request not executed");

	a_no_stalled_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |-> !wr_en)
		else $error("write-back while result register blocked");

endmodule
